/* sv/kfsc_pkg.sv */
// Package for the keyframe speed curve table: sizes, codes, channel words, command types.
// No dependencies.
package kfsc_pkg;

    localparam int MaxPoints = 16;
    localparam int IdxW      = $clog2(MaxPoints);
    localparam int CntW      = $clog2(MaxPoints + 1);

    localparam logic [15:0] SpeedMin = 16'd410;
    localparam logic [15:0] SpeedMax = 16'd40960;
    localparam logic [15:0] SpeedOne = 16'd4096;

    typedef enum logic [1:0] {
        KIND_ADD    = 2'd0,
        KIND_REMOVE = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_QUERY  = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        EASE_LINEAR = 2'd0,
        EASE_IN     = 2'd1,
        EASE_OUT    = 2'd2,
        EASE_INOUT  = 2'd3
    } ease_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // input word
    typedef struct packed {
        kind_t       kind;
        logic [31:0] time_ms;
        logic [15:0] speed_in;
        ease_t       easing_mode;
        logic [3:0]  point_index;
    } in_word_t;

    // result word
    typedef struct packed {
        logic [15:0] speed_out;
        status_t     status;
        logic [4:0]  point_count;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_UP,
        S_SHIFT_DOWN,
        S_QLOAD,
        S_DIV,
        S_EASE,
        S_BLEND,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input word
        logic scan_inc;
        logic shift_up;    // entry[i] <= entry[i-1], i--
        logic shift_down;  // entry[i] <= entry[i+1], i++
        logic write_new;   // write new point at scan index
        logic write_repl;  // replace speed/easing at scan index
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic set_remove;  // scan index <= point_index
        logic set_top;     // scan index <= count
        logic qload;       // load divider operands
        logic div_step;
        logic ease_step;
        logic blend_step;
        logic set_speed_end;
        logic out_load;
        status_t status;
    } kfsc_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_end;    // scan index reached count
        logic match;       // time at scan index equals input time
        logic greater;     // time at scan index at or above input time
        logic shift_done;
        logic full;
        logic empty;
        logic idx_bad;
        logic q_end;       // query resolved to an end point
        logic div_done;
    } kfsc_sts_t;

endpackage

/* sv/kfsc_if.sv */
// Valid/ready channels carrying one input word and one result word.
// Depends on kfsc_pkg.
interface kfsc_in_if
    import kfsc_pkg::*;
();
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface kfsc_out_if
    import kfsc_pkg::*;
();
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* sv/kfsc_ctrl.sv */
// Controller state machine for the keyframe table.
// Depends on kfsc_pkg.
module kfsc_ctrl
    import kfsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  kind_t      in_kind,
    output logic       out_valid,
    input  logic       out_ready,
    output kfsc_cmd_t  cmd,
    input  kfsc_sts_t  sts
);

    state_t  state_reg, state_next;
    kind_t   kind_reg, kind_next;
    status_t status_reg, status_next;
    logic    ovalid_reg, ovalid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= KIND_ADD;
            status_reg <= ST_OK;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid = ovalid_reg;
    // a waiting result word only holds the next item at S_DONE
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        ovalid_next = ovalid_reg && !out_ready;
        cmd         = '0;
        cmd.status  = ST_OK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load    = 1'b1;
                    kind_next   = in_kind;
                    status_next = ST_OK;
                    unique case (in_kind)
                        KIND_CLEAR:  state_next = S_DONE;
                        KIND_REMOVE: state_next = S_SHIFT_DOWN;
                        default:     state_next = S_SCAN;
                    endcase
                    if (in_kind == KIND_REMOVE)
                        cmd.set_remove = 1'b1;
                end
            end
            S_SCAN:
            begin
                // add: look for same time; query: find first time at or above q
                if (kind_reg == KIND_ADD)
                begin
                    if (sts.scan_end)
                    begin
                        if (sts.full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            cmd.set_top = 1'b1;
                            state_next  = S_SHIFT_UP;
                        end
                    end
                    else if (sts.match)
                    begin
                        cmd.write_repl = 1'b1;
                        state_next     = S_DONE;
                    end
                    else
                        cmd.scan_inc = 1'b1;
                end
                else
                begin
                    if (sts.q_end)
                    begin
                        cmd.set_speed_end = 1'b1;
                        state_next        = S_DONE;
                    end
                    else if (sts.greater)
                    begin
                        cmd.qload  = 1'b1;
                        state_next = S_QLOAD;
                    end
                    else
                        cmd.scan_inc = 1'b1;
                end
            end
            S_SHIFT_UP:
            begin
                if (sts.shift_done)
                begin
                    cmd.write_new = 1'b1;
                    cmd.cnt_inc   = 1'b1;
                    state_next    = S_DONE;
                end
                else
                    cmd.shift_up = 1'b1;
            end
            S_SHIFT_DOWN:
            begin
                if (sts.idx_bad)
                begin
                    status_next = ST_RANGE;
                    state_next  = S_DONE;
                end
                else if (sts.shift_done)
                begin
                    cmd.cnt_dec = 1'b1;
                    state_next  = S_DONE;
                end
                else
                    cmd.shift_down = 1'b1;
            end
            S_QLOAD:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = S_EASE;
            end
            S_EASE:
            begin
                cmd.ease_step = 1'b1;
                state_next    = S_BLEND;
            end
            S_BLEND:
            begin
                cmd.blend_step = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    cmd.status   = status_reg;
                    if (kind_reg == KIND_CLEAR)
                        cmd.cnt_clr = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* sv/kfsc_dp.sv */
// Datapath: keyframe register file, scan pointer, serial divider, easing and blend.
// Depends on kfsc_pkg.
module kfsc_dp
    import kfsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  kind_t       in_kind,
    input  logic [31:0] in_time,
    input  logic [15:0] in_speed,
    input  ease_t       in_ease,
    input  logic [3:0]  in_index,
    input  kfsc_cmd_t   cmd,
    output kfsc_sts_t   sts,
    output logic [15:0] speed_out,
    output status_t     status,
    output logic [4:0]  point_count
);

    logic [31:0] times_reg  [MaxPoints];
    logic [15:0] speeds_reg [MaxPoints];
    ease_t       eases_reg  [MaxPoints];

    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] ptr_reg;   // scan / shift index, may equal count
    logic [31:0]     t_reg;
    logic [15:0]     s_reg;
    ease_t           e_reg;
    logic [3:0]      idx_reg;
    kind_t           kind_reg;

    // divider and blend
    logic [47:0] rem_reg;
    logic [31:0] den_reg;
    logic [16:0] quo_reg;
    logic [4:0]  dcnt_reg;
    logic [15:0] sa_reg, sb_reg;
    ease_t       ea_reg;
    logic [16:0] ef_reg;
    logic [15:0] spd_reg, res_reg;
    status_t     stat_reg;
    logic [4:0]  pcnt_reg;

    logic [IdxW-1:0] pi;
    logic [31:0]     t_at;
    logic [15:0]     s_clamp;
    logic            at_last;
    logic [IdxW-1:0] last_i;
    logic            kind_reg_is_remove;

    assign pi     = ptr_reg[IdxW-1:0];
    assign t_at   = times_reg[pi];
    assign last_i = IdxW'(cnt_reg - 1'b1);
    assign at_last = (ptr_reg == cnt_reg - 1'b1);
    assign kind_reg_is_remove = (kind_reg == KIND_REMOVE);

    always_comb
    begin
        s_clamp = in_speed;
        if (in_speed < SpeedMin)
            s_clamp = SpeedMin;
        else if (in_speed > SpeedMax)
            s_clamp = SpeedMax;
    end

    always_comb
    begin
        sts            = '0;
        sts.scan_end   = (ptr_reg == cnt_reg);
        sts.match      = !sts.scan_end && t_at == t_reg;
        sts.greater    = t_at >= t_reg;
        sts.full       = (cnt_reg == CntW'(MaxPoints));
        sts.empty      = (cnt_reg == '0);
        sts.idx_bad    = ({1'b0, idx_reg} >= cnt_reg);
        sts.div_done   = (dcnt_reg == 5'd0);
        sts.shift_done = (kind_reg_is_remove) ? (ptr_reg + 1'b1 >= cnt_reg)
                                              : (ptr_reg == '0 || times_reg[pi - 1'b1] < t_reg);
        // query: empty, single, at/before first, or at/after last
        sts.q_end      = sts.empty || cnt_reg == CntW'(1) ||
                         (ptr_reg == '0 && t_reg <= t_at) ||
                         (at_last && t_reg >= t_at);
    end

    // ease product operands
    logic [16:0] f17;
    logic [33:0] eprod;
    logic [31:0] bprod;
    logic [15:0] sdiff;
    assign f17 = quo_reg;
    always_comb
    begin
        unique case (ea_reg)
            EASE_IN:  eprod = 34'(f17) * 34'(f17);
            EASE_OUT: eprod = 34'(f17) * (34'd131072 - 34'(f17));
            EASE_INOUT:
                if (f17 < 17'd32768)
                    eprod = 34'(f17) * 34'(f17) << 1;
                else
                    eprod = (34'd262144 - (34'(f17) << 1)) * 34'(f17) - 34'h1_0000_0000;
            default:  eprod = 34'(f17) << 16;
        endcase
    end
    assign sdiff = (sb_reg >= sa_reg) ? sb_reg - sa_reg : sa_reg - sb_reg;
    assign bprod = 32'(sdiff) * 32'(ef_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            ptr_reg     <= '0;
            dcnt_reg    <= '0;
            kind_reg    <= KIND_ADD;
        end
        else
        begin
            if (cmd.load)
            begin
                kind_reg    <= in_kind;
                t_reg       <= in_time;
                s_reg       <= s_clamp;
                e_reg       <= in_ease;
                idx_reg     <= in_index;
                ptr_reg     <= cmd.set_remove ? CntW'(in_index) : '0;
            end
            if (cmd.scan_inc)
                ptr_reg <= ptr_reg + 1'b1;
            if (cmd.set_top)
                ptr_reg <= cnt_reg;
            if (cmd.write_repl)
            begin
                speeds_reg[pi] <= s_reg;
                eases_reg[pi]  <= e_reg;
            end
            if (cmd.shift_up)
            begin
                times_reg[pi]  <= times_reg[pi - 1'b1];
                speeds_reg[pi] <= speeds_reg[pi - 1'b1];
                eases_reg[pi]  <= eases_reg[pi - 1'b1];
                ptr_reg        <= ptr_reg - 1'b1;
            end
            if (cmd.shift_down)
            begin
                times_reg[pi]  <= times_reg[pi + 1'b1];
                speeds_reg[pi] <= speeds_reg[pi + 1'b1];
                eases_reg[pi]  <= eases_reg[pi + 1'b1];
                ptr_reg        <= ptr_reg + 1'b1;
            end
            if (cmd.write_new)
            begin
                times_reg[pi]  <= t_reg;
                speeds_reg[pi] <= s_reg;
                eases_reg[pi]  <= e_reg;
            end
            if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + 1'b1;
            if (cmd.cnt_dec)
                cnt_reg <= cnt_reg - 1'b1;
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            if (cmd.qload)
                dcnt_reg <= 5'd17;
            else if (cmd.div_step && dcnt_reg != 5'd0)
                dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    // restoring divider, one quotient bit a cycle; divides (q-ta)<<16 by (tb-ta)
    logic [48:0] trial;
    assign trial = {rem_reg, 1'b0} - {17'd0, den_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.qload)
        begin
            // interval is [ptr-1, ptr]; q <= tb, so 16 steps give the fraction,
            // and q == tb comes out all ones (65535)
            rem_reg <= {16'd0, t_reg - times_reg[pi - 1'b1]};
            den_reg <= t_at - times_reg[pi - 1'b1];
            quo_reg <= '0;
            sa_reg  <= speeds_reg[pi - 1'b1];
            sb_reg  <= speeds_reg[pi];
            ea_reg  <= eases_reg[pi - 1'b1];
        end
        else if (cmd.div_step && dcnt_reg > 5'd1)
        begin
            if (!trial[48])
            begin
                rem_reg <= trial[47:0];
                quo_reg <= {quo_reg[15:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[46:0], 1'b0};
                quo_reg <= {quo_reg[15:0], 1'b0};
            end
        end
        if (cmd.ease_step)
            ef_reg <= 17'(eprod >> 16);
        if (cmd.blend_step)
            spd_reg <= (sb_reg >= sa_reg) ? sa_reg + 16'(bprod >> 16)
                                          : sa_reg - 16'(bprod >> 16);
        if (cmd.set_speed_end)
            spd_reg <= (cnt_reg == '0) ? SpeedOne :
                       (ptr_reg == '0 || cnt_reg == CntW'(1)) ? speeds_reg[0]
                                                              : speeds_reg[last_i];
        if (cmd.out_load)
        begin
            res_reg  <= (kind_reg == KIND_QUERY) ? spd_reg : SpeedOne;
            stat_reg <= cmd.status;
            pcnt_reg <= cmd.cnt_clr ? 5'd0 : 5'(cnt_reg);
        end
    end

    assign speed_out   = res_reg;
    assign status      = stat_reg;
    assign point_count = pcnt_reg;

endmodule

/* sv/keyframe_speed_curve_table_top.sv */
// Keyframe speed curve table: up to 16 time-sorted speed points, eased queries.
// Depends on kfsc_pkg, kfsc_if, kfsc_ctrl and kfsc_dp.
// A query runs a scan of up to 16 entries, the serial divider, then the ease and blend
// multiplies.
// One item at a time; a result waiting on out_ready stalls only the next one at its end.
// Reset (rst_n low, async) empties the table; point storage is not cleared.
module keyframe_speed_curve_table_top
    import kfsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    kfsc_in_if.sink    in_ch,
    kfsc_out_if.source out_ch
);

    kfsc_cmd_t cmd;
    kfsc_sts_t sts;

    kfsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_kind   (in_ch.data.kind),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    kfsc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_kind     (in_ch.data.kind),
        .in_time     (in_ch.data.time_ms),
        .in_speed    (in_ch.data.speed_in),
        .in_ease     (in_ch.data.easing_mode),
        .in_index    (in_ch.data.point_index),
        .cmd         (cmd),
        .sts         (sts),
        .speed_out   (out_ch.data.speed_out),
        .status      (out_ch.data.status),
        .point_count (out_ch.data.point_count)
    );

endmodule
